// ----- rtl/core/kvrd_pkg.sv -----
`timescale 1ns / 1ps

package kvrd_pkg;

	// result kinds
	typedef enum logic [2:0] {
		K_KEY  = 3'd0,
		K_STR  = 3'd1,
		K_INT  = 3'd2,
		K_ESTR = 3'd3,
		K_EKEY = 3'd4,
		K_ERR  = 3'd5
	} kind_t;

	// error codes
	typedef enum logic [2:0] {
		E_NONE   = 3'd0,
		E_FLOAT  = 3'd1,
		E_UNUSED = 3'd2,
		E_EXTNUM = 3'd3,
		E_EXTVAL = 3'd4,
		E_TRUNC  = 3'd5
	} err_t;

	// decode phase, one-hot
	typedef enum logic [4:0] {
		PH_KEYLEN = 5'b00001,
		PH_KEY    = 5'b00010,
		PH_TAG    = 5'b00100,
		PH_INT    = 5'b01000,
		PH_STR    = 5'b10000
	} phase_t;

	// tag byte top bits
	localparam logic [1:0] TAG_SMALL = 2'd0;
	localparam logic [1:0] TAG_NUM   = 2'd1;
	localparam logic [1:0] TAG_STR   = 2'd2;

	// number sub-kinds
	localparam logic [1:0] NUM_INT    = 2'd0;
	localparam logic [1:0] NUM_FLOAT  = 2'd1;
	localparam logic [1:0] NUM_UNUSED = 2'd2;

	localparam int OUT_INT_W = 32;
	localparam int TDATA_PAD = 5;

	// one classified result, front to back
	typedef struct packed {
		kind_t                  kind;
		logic [7:0]             data;
		logic [OUT_INT_W-1:0]   acc;
		logic                   neg;
		logic                   eof;
		err_t                   err;
	} op_t;

endpackage

// ----- rtl/core/key_value_record_decoder_top.sv -----
`timescale 1ns / 1ps

// channel   dir  tdata                                   tlast          tuser
// s_axis    in   [7:0] in_byte                           end_of_buffer  -
// m_axis    out  [7:0] data_byte, [39:8] int_value,      end_of_field   [2:0] kind
//                [42:40] error_code, [47:43] zero
//
// One byte per cycle while the result queue is not full; the front phase machine decides
// each byte combinationally and the back stage registers one result per cycle while the
// output is not stalled. Results pass through the queue entry and the back output register.
// Reset (arst_n low) puts the decoder at the start of a record with empty queue.
// Output stalls fill the result queue; s_tready drops only when it is full.

module key_value_record_decoder_top #(
	parameter int INT_WIDTH   = 32,   // integer accumulator width, 32..64
	parameter int QUEUE_DEPTH = 4     // results buffered between front and back
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,  // [7:0] in_byte
	input  logic            s_tlast,  // end_of_buffer
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [47:0]     m_tdata,  // [7:0] data_byte, [39:8] int_value, [42:40] error_code
	output logic            m_tlast,  // end_of_field
	output logic [2:0]      m_tuser   // [2:0] kind
);
	import kvrd_pkg::*;

	logic   accept;
	logic   push;
	op_t    push_op;
	logic   q_full;
	logic   q_valid;
	logic   pop;
	op_t    head_op;

	// front may advance whenever the queue has room for a possible result
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	kvrd_front #(
		.INT_WIDTH(INT_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (s_tdata),
		.eob     (s_tlast),
		.push    (push),
		.op      (push_op)
	);

	kvrd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.valid   (q_valid),
		.pop     (pop),
		.head_op (head_op)
	);

	// back: sign fix-up and output register
	kvrd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_op     (head_op),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- rtl/core/kvrd_front.sv -----
`timescale 1ns / 1ps

module kvrd_front #(
	parameter int INT_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      in_byte,
	input  logic            eob,
	output logic            push,
	output kvrd_pkg::op_t   op
);
	import kvrd_pkg::*;

	phase_t                 phase_q, phase_nxt;
	logic [7:0]             left_q, left_nxt;
	logic [INT_WIDTH-1:0]   acc_q, acc_nxt;
	logic                   neg_q, neg_nxt;
	logic                   skip_q, skip_nxt;
	logic                   emit;
	logic                   last_one;

	assign last_one = (left_q == 8'd1);

	always_comb begin
		phase_nxt = phase_q;
		left_nxt  = left_q;
		acc_nxt   = acc_q;
		neg_nxt   = neg_q;
		skip_nxt  = skip_q;
		emit      = 1'b0;
		op        = '0;
		op.kind   = K_KEY;
		op.err    = E_NONE;

		if (skip_q) begin
			if (eob) begin
				skip_nxt = 1'b0;
			end
		end else begin
			unique case (phase_q)
				PH_KEY: begin
					if (eob) begin
						emit = 1'b1;
						op.kind = K_ERR;
						op.err = E_TRUNC;
					end else begin
						emit = 1'b1;
						op.kind = K_KEY;
						op.data = in_byte;
						op.eof = last_one;
						left_nxt = left_q - 8'd1;
						if (last_one) begin
							phase_nxt = PH_TAG;
						end
					end
				end
				PH_TAG: begin
					case (in_byte[7:6])
						TAG_SMALL: begin
							emit = 1'b1;
							op.kind = K_INT;
							op.acc = {{(OUT_INT_W-6){in_byte[5]}}, in_byte[5:0]};
							phase_nxt = PH_KEYLEN;
						end
						TAG_NUM: begin
							if (in_byte[5:4] == NUM_FLOAT) begin
								emit = 1'b1;
								op.kind = K_ERR;
								op.err = E_FLOAT;
							end else if (in_byte[5:4] == NUM_UNUSED) begin
								emit = 1'b1;
								op.kind = K_ERR;
								op.err = E_UNUSED;
							end else if (in_byte[5:4] != NUM_INT) begin
								emit = 1'b1;
								op.kind = K_ERR;
								op.err = E_EXTNUM;
							end else if (eob) begin
								emit = 1'b1;
								op.kind = K_ERR;
								op.err = E_TRUNC;
							end else begin
								left_nxt = {5'd0, in_byte[2:0]} + 8'd1;
								neg_nxt = in_byte[3];
								acc_nxt = '0;
								phase_nxt = PH_INT;
							end
						end
						TAG_STR: begin
							if (in_byte[5:0] == 6'd0) begin
								emit = 1'b1;
								op.kind = K_ESTR;
								phase_nxt = PH_KEYLEN;
							end else if (eob) begin
								emit = 1'b1;
								op.kind = K_ERR;
								op.err = E_TRUNC;
							end else begin
								left_nxt = {2'd0, in_byte[5:0]};
								phase_nxt = PH_STR;
							end
						end
						default: begin
							emit = 1'b1;
							op.kind = K_ERR;
							op.err = E_EXTVAL;
						end
					endcase
				end
				PH_INT: begin
					acc_nxt = {acc_q[INT_WIDTH-9:0], in_byte};
					left_nxt = left_q - 8'd1;
					if (last_one) begin
						emit = 1'b1;
						op.kind = K_INT;
						op.acc = acc_nxt[OUT_INT_W-1:0];
						op.neg = neg_q;
						phase_nxt = PH_KEYLEN;
					end else if (eob) begin
						emit = 1'b1;
						op.kind = K_ERR;
						op.err = E_TRUNC;
					end
				end
				PH_STR: begin
					if (eob && !last_one) begin
						emit = 1'b1;
						op.kind = K_ERR;
						op.err = E_TRUNC;
					end else begin
						emit = 1'b1;
						op.kind = K_STR;
						op.data = in_byte;
						op.eof = last_one;
						left_nxt = left_q - 8'd1;
						if (last_one) begin
							phase_nxt = PH_KEYLEN;
						end
					end
				end
				PH_KEYLEN: begin
					if (eob) begin
						emit = 1'b1;
						op.kind = K_ERR;
						op.err = E_TRUNC;
					end else if (in_byte == 8'd0) begin
						emit = 1'b1;
						op.kind = K_EKEY;
						phase_nxt = PH_TAG;
					end else begin
						left_nxt = in_byte;
						phase_nxt = PH_KEY;
					end
				end
				default: begin
					phase_nxt = PH_KEYLEN;
				end
			endcase

			// any error: restart, skip to buffer end unless already there
			if (emit && op.kind == K_ERR) begin
				phase_nxt = PH_KEYLEN;
				left_nxt = 8'd0;
				skip_nxt = !eob;
			end
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEYLEN;
			left_q  <= 8'd0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			skip_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			left_q  <= left_nxt;
			acc_q   <= acc_nxt;
			neg_q   <= neg_nxt;
			skip_q  <= skip_nxt;
		end
	end

	a_skip_restart: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> phase_q == PH_KEYLEN)
		else $error("skipping outside key length phase");

	a_counted_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_KEY || phase_q == PH_STR || phase_q == PH_INT) |-> left_q != 8'd0)
		else $error("counted phase with zero bytes left");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		push && op.kind == K_ERR |=> phase_q == PH_KEYLEN)
		else $error("error did not restart decoding");

endmodule

// ----- rtl/core/kvrd_queue.sv -----
`timescale 1ns / 1ps

module kvrd_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  kvrd_pkg::op_t   push_op,
	output logic            full,
	output logic            valid,
	input  logic            pop,
	output kvrd_pkg::op_t   head_op
);
	import kvrd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	op_t                entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign head_op = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!valid |-> !pop)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

endmodule

// ----- rtl/core/kvrd_back.sv -----
`timescale 1ns / 1ps

module kvrd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  kvrd_pkg::op_t   q_op,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [47:0]     m_tdata,
	output logic            m_tlast,
	output logic [2:0]      m_tuser
);
	import kvrd_pkg::*;

	logic                   vld_q;
	kind_t                  kind_q;
	logic [7:0]             data_q;
	logic [OUT_INT_W-1:0]   ival_q, ival;
	logic                   eof_q;
	err_t                   err_q;

	// apply sign of a sign-and-magnitude integer
	assign ival = q_op.neg ? (~q_op.acc + 1'b1) : q_op.acc;
	assign pop  = q_valid && (!vld_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= q_op.kind;
			data_q <= q_op.data;
			ival_q <= ival;
			eof_q  <= q_op.eof;
			err_q  <= q_op.err;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {{TDATA_PAD{1'b0}}, err_q, ival_q, data_q};
	assign m_tlast  = eof_q;
	assign m_tuser  = kind_q;

	a_err_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && kind_q == K_ERR |-> err_q != E_NONE)
		else $error("error result without code");

	a_ok_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && kind_q != K_ERR |-> err_q == E_NONE)
		else $error("code on non-error result");

	a_eof_only_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && eof_q |-> (kind_q == K_KEY || kind_q == K_STR))
		else $error("end of field on non-byte result");

endmodule

// ----- tb/sv/tb_key_value_record_decoder_top.sv -----
`timescale 1ns / 1ps

module tb_key_value_record_decoder_top;

	import kvrd_pkg::*;

	localparam int INT_WIDTH      = 32;
	localparam int RESET_CYCLES   = 9;
	localparam int IDLE_PCT       = 19;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;

	// tag forms the package leaves unnamed
	localparam logic [1:0] TAG_EXT = 2'd3;
	localparam logic [1:0] NUM_EXT = 2'd3;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [31:0] value;
		logic        eof;
		err_t        err;
	} kv_record_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic [2:0]  m_tuser;

	// decoder state as predicted
	phase_t               dec_phase = PH_KEYLEN;
	logic [7:0]           dec_left  = 8'd0;
	logic [INT_WIDTH-1:0] dec_acc   = '0;
	logic                 dec_neg   = 1'b0;
	logic                 dec_skip  = 1'b0;

	kv_record_t expected_records[$];
	int         fail_count   = 0;
	int         live_items   = 0;
	int         quiet_cycles = 0;
	bit         src_idle_en  = 1'b1;
	bit         sink_idle_en = 1'b1;
	bit         hold_request = 1'b0;
	bit         sink_hold    = 1'b0;

	key_value_record_decoder_top #(
		.INT_WIDTH(INT_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	function automatic kv_record_t make_rec(kind_t k, logic [7:0] d, logic [31:0] v,
			logic eof, err_t e);
		kv_record_t r;
		r.kind  = k;
		r.data  = d;
		r.value = v;
		r.eof   = eof;
		r.err   = e;
		return r;
	endfunction

	// error: back to a key length, skip the rest of the buffer unless this byte ended it
	function automatic kv_record_t abort_record(err_t code, logic eob);
		dec_phase = PH_KEYLEN;
		dec_left  = 8'd0;
		dec_skip  = !eob;
		return make_rec(K_ERR, 8'h00, 32'h0, 1'b0, code);
	endfunction

	// advances the predicted state by one byte; returns 1 when a result is due
	function automatic bit decode_byte(input logic [7:0] b, input logic eob,
			output kv_record_t r);
		bit                   hit;
		logic [INT_WIDTH-1:0] num;
		hit = 1'b1;
		r   = make_rec(K_KEY, 8'h00, 32'h0, 1'b0, E_NONE);
		if (dec_skip) begin
			if (eob)
				dec_skip = 1'b0;
			hit = 1'b0;
		end else begin
			case (dec_phase)
				PH_KEY: begin
					// a value must still follow the key
					if (eob)
						r = abort_record(E_TRUNC, eob);
					else begin
						r = make_rec(K_KEY, b, 32'h0, dec_left == 8'd1, E_NONE);
						dec_left = dec_left - 8'd1;
						if (dec_left == 8'd0)
							dec_phase = PH_TAG;
					end
				end
				PH_TAG: begin
					case (b[7:6])
						TAG_SMALL: begin
							dec_phase = PH_KEYLEN;
							r = make_rec(K_INT, 8'h00, {{26{b[5]}}, b[5:0]}, 1'b0, E_NONE);
						end
						TAG_NUM: begin
							case (b[5:4])
								NUM_FLOAT:  r = abort_record(E_FLOAT, eob);
								NUM_UNUSED: r = abort_record(E_UNUSED, eob);
								NUM_EXT:    r = abort_record(E_EXTNUM, eob);
								default: begin
									if (eob)
										r = abort_record(E_TRUNC, eob);
									else begin
										dec_left  = {5'd0, b[2:0]} + 8'd1;
										dec_neg   = b[3];
										dec_acc   = '0;
										dec_phase = PH_INT;
										hit       = 1'b0;
									end
								end
							endcase
						end
						TAG_STR: begin
							if (b[5:0] == 6'd0) begin
								dec_phase = PH_KEYLEN;
								r = make_rec(K_ESTR, 8'h00, 32'h0, 1'b0, E_NONE);
							end else if (eob)
								r = abort_record(E_TRUNC, eob);
							else begin
								dec_left  = {2'd0, b[5:0]};
								dec_phase = PH_STR;
								hit       = 1'b0;
							end
						end
						default: r = abort_record(E_EXTVAL, eob);
					endcase
				end
				PH_INT: begin
					// big-endian magnitude, high bytes fall off the top
					dec_acc  = {dec_acc[INT_WIDTH-9:0], b};
					dec_left = dec_left - 8'd1;
					if (dec_left == 8'd0) begin
						num       = dec_neg ? -dec_acc : dec_acc;
						dec_phase = PH_KEYLEN;
						r = make_rec(K_INT, 8'h00, num[31:0], 1'b0, E_NONE);
					end else if (eob)
						r = abort_record(E_TRUNC, eob);
					else
						hit = 1'b0;
				end
				PH_STR: begin
					if (eob && dec_left != 8'd1)
						r = abort_record(E_TRUNC, eob);
					else begin
						r = make_rec(K_STR, b, 32'h0, dec_left == 8'd1, E_NONE);
						dec_left = dec_left - 8'd1;
						if (dec_left == 8'd0)
							dec_phase = PH_KEYLEN;
					end
				end
				default: begin
					if (eob)
						r = abort_record(E_TRUNC, eob);
					else if (b == 8'd0) begin
						dec_phase = PH_TAG;
						r = make_rec(K_EKEY, 8'h00, 32'h0, 1'b0, E_NONE);
					end else begin
						dec_left  = b;
						dec_phase = PH_KEY;
						hit       = 1'b0;
					end
				end
			endcase
		end
		return hit;
	endfunction

	function automatic void log_failure(string what, kv_record_t want, kv_record_t got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s: expected kind %0d data %h value %h eof %b err %0d, %s",
				$time, what, want.kind, want.data, want.value, want.eof, want.err,
				$sformatf("got kind %0d data %h value %h eof %b err %0d",
					got.kind, got.data, got.value, got.eof, got.err));
	endfunction

	// one byte transaction on the input side; the prediction runs on acceptance
	task automatic send_byte(input logic [7:0] b, input logic eob);
		kv_record_t rec;
		while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eob;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		live_items++;
		if (decode_byte(b, eob, rec))
			expected_records.push_back(rec);
	endtask

	task automatic send_frame(input logic [7:0] q[$]);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1);
	endtask

	// one record with random content, mostly well formed
	function automatic void append_record(ref logic [7:0] q[$]);
		int klen;
		int vlen;
		int pick;
		pick = $urandom_range(99);
		klen = (pick < 15) ? 0 :
			(pick < 98) ? $urandom_range(6, 1) : $urandom_range(255, 64);
		q.push_back(8'(klen));
		repeat (klen)
			q.push_back(8'($urandom_range(255)));
		pick = $urandom_range(99);
		if (pick < 25)
			q.push_back({TAG_SMALL, 6'($urandom_range(63))});
		else if (pick < 55) begin
			vlen = $urandom_range(8, 1);
			q.push_back({TAG_NUM, NUM_INT, 1'($urandom_range(1)), 3'(vlen - 1)});
			repeat (vlen)
				q.push_back(($urandom_range(4) == 0) ? 8'hFF : 8'($urandom_range(255)));
		end else if (pick < 92) begin
			vlen = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(6);
			q.push_back({TAG_STR, 6'(vlen)});
			repeat (vlen)
				q.push_back(8'($urandom_range(255)));
		end else begin
			case ($urandom_range(3))
				0:       q.push_back({TAG_NUM, NUM_FLOAT, 4'($urandom_range(15))});
				1:       q.push_back({TAG_NUM, NUM_UNUSED, 4'($urandom_range(15))});
				2:       q.push_back({TAG_NUM, NUM_EXT, 4'($urandom_range(15))});
				default: q.push_back({TAG_EXT, 6'($urandom_range(63))});
			endcase
		end
	endfunction

	// each entry is {end_of_buffer, byte}
	task automatic test_directed();
		logic [8:0] seq[$];
		seq = '{
			9'h001, 9'h0FF, 9'h000,          // one-byte key, small int zero
			9'h000, 9'h03F,                  // empty key, small int -1
			9'h000, 9'h080,                  // empty string
			9'h000, 9'h081, 9'h041,          // one-byte string
			9'h000, 9'h041, 9'h012, 9'h034,  // two-byte positive integer
			9'h000, 9'h048, 9'h080,          // one-byte negative integer
			9'h000, 9'h150,                  // float tag ending the buffer
			9'h000, 9'h060, 9'h077, 9'h100,  // unused number, rest skipped
			9'h000, 9'h170,                  // extended number
			9'h000, 9'h1C0,                  // extended value
			9'h105                           // buffer ends on a key length
		};
		foreach (seq[i])
			send_byte(seq[i][7:0], seq[i][8]);
	endtask

	task automatic test_random_records(input int target);
		logic [7:0] frame[$];
		int         pick;
		int         cut;
		live_items = 0;
		while (live_items < target) begin
			frame.delete();
			pick = $urandom_range(99);
			if (pick < 5) begin
				// noise buffer
				repeat ($urandom_range(8, 1))
					frame.push_back(8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(4, 1))
					append_record(frame);
				// buffer cut short somewhere inside
				if (pick < 15) begin
					cut = $urandom_range(frame.size() - 1);
					while (frame.size() > cut + 1)
						void'(frame.pop_back());
				end
			end
			send_frame(frame);
		end
	endtask

	task automatic test_back_to_back(input int target);
		src_idle_en  <= 1'b0;
		sink_idle_en <= 1'b0;
		test_random_records(target);
		src_idle_en  <= 1'b1;
		sink_idle_en <= 1'b1;
	endtask

	// sink holds off while a long record keeps arriving, filling the result queue
	task automatic test_output_hold();
		logic [7:0] frame[$];
		hold_request = 1'b1;
		frame.push_back(8'd20);
		repeat (20)
			frame.push_back(8'($urandom_range(255)));
		frame.push_back({TAG_STR, 6'd30});
		repeat (30)
			frame.push_back(8'($urandom_range(255)));
		send_frame(frame);
	endtask

	initial begin : hold_off
		forever begin
			wait (hold_request);
			sink_hold <= 1'b1;
			repeat (HOLD_CYCLES)
				@(posedge clk);
			sink_hold <= 1'b0;
			hold_request = 1'b0;
		end
	end

	// result side: check each output transaction, then pick next tready
	always @(posedge clk) begin : result_check
		kv_record_t got;
		kv_record_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = make_rec(kind_t'(m_tuser), m_tdata[7:0], m_tdata[39:8], m_tlast,
				err_t'(m_tdata[42:40]));
			if (expected_records.size() == 0)
				log_failure("result with none expected", '0, got);
			else begin
				want = expected_records.pop_front();
				if (got.kind !== want.kind || got.data !== want.data ||
						got.value !== want.value || got.eof !== want.eof ||
						got.err !== want.err)
					log_failure("result mismatch", want, got);
			end
		end
		m_tready <= !sink_hold && !(sink_idle_en && $urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_key_value_record_decoder_top failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_records(280);
		test_back_to_back(120);
		test_output_hold();
		test_random_records(230);

		s_tvalid <= 1'b0;
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("tb_key_value_record_decoder_top passed");
		else
			$display("tb_key_value_record_decoder_top failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/kvrd_pkg.sv
rtl/core/kvrd_front.sv
rtl/core/kvrd_queue.sv
rtl/core/kvrd_back.sv
rtl/core/key_value_record_decoder_top.sv
tb/sv/tb_key_value_record_decoder_top.sv
